// ----- sv/sfr_pkg.sv -----
// Shared types, constants and the CRC-16 byte update for the serial frame receiver.
package sfr_pkg;

  localparam logic [12:0] MAX_PAYLOAD    = 13'd4096;
  localparam logic [12:0] MAX_LEN_RESET  = 13'd4096;
  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [15:0] CRC_POLY       = 16'h1021;
  localparam logic [7:0]  START_BYTE     = 8'h02;

  localparam logic        OP_BYTE        = 1'b0;
  localparam logic        OP_TIMEOUT     = 1'b1;

  localparam logic        REG_MAX_LEN    = 1'b0;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_HEADER  = 3'd1,
    PH_PAYLOAD = 3'd2,
    PH_CRC_HI  = 3'd3,
    PH_CRC_LO  = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_START = 3'd1,
    ST_TOO_LONG  = 3'd2,
    ST_BAD_CRC   = 3'd3,
    ST_MUTE      = 3'd4,
    ST_STOPPED   = 3'd5
  } status_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        is_end;
    status_t     status;
    logic [15:0] frame_length;
    logic [7:0]  frame_address;
    logic [7:0]  frame_protocol;
  } result_t;

  // One byte of CRC-16/CCITT-FALSE, MSB first.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- sv/sfr_out_buf.sv -----
// Two-entry output register with skid stage for result beats.
module sfr_out_buf (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_vld,
  input  sfr_pkg::result_t push_data,
  output logic             push_ok,
  output logic             out_vld,
  output sfr_pkg::result_t out_data,
  input  logic             out_rdy
);
  import sfr_pkg::*;

  logic    head_vld_r, head_vld_nxt;
  logic    skid_vld_r, skid_vld_nxt;
  result_t head_r, head_nxt;
  result_t skid_r, skid_nxt;
  logic    pop;

  // Accept a push only while the skid slot is free: a registered condition.
  assign push_ok  = !skid_vld_r;
  assign out_vld  = head_vld_r;
  assign out_data = head_r;
  assign pop      = head_vld_r && out_rdy;

  always_comb begin
    head_vld_nxt = head_vld_r;
    skid_vld_nxt = skid_vld_r;
    head_nxt     = head_r;
    skid_nxt     = skid_r;
    if (pop) begin
      if (skid_vld_r) begin
        head_nxt     = skid_r;
        skid_vld_nxt = 1'b0;
      end else if (push_vld) begin
        head_nxt     = push_data;
      end else begin
        head_vld_nxt = 1'b0;
      end
    end else if (push_vld && push_ok) begin
      if (!head_vld_r) begin
        head_nxt     = push_data;
        head_vld_nxt = 1'b1;
      end else begin
        skid_nxt     = push_data;
        skid_vld_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      head_vld_r <= head_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

endmodule

// ----- sv/serial_frame_receiver_crc16.sv -----
// Top level of the byte-serial frame receiver with CRC-16 check.
//
// Usage: feed one beat per received byte on the in_ stream (in_tuser = 0,
// in_tdata = byte) or one beat with in_tuser = 1 when the receive timeout
// expires. A frame is 0x02, length (big endian), address, protocol, payload,
// CRC high, CRC low. Each payload byte comes out as a beat with out_tlast = 0;
// every frame, good or bad, closes with one beat with out_tlast = 1 whose
// out_tuser carries the status and out_tdata the header values.
// Path: a taken input beat is held in the input register, and its result beat
// goes to the result register when the parser processes it.
// Throughput: one input beat per cycle while the result stages have room, set
// by the combinational byte-wise CRC and parser update.
// Backpressure: when out_tready is low the result register and its skid
// stage fill, then in_tready falls; no beat is lost or repeated.
// Reset (rst_n low, synchronous): parser returns to idle waiting for 0x02,
// CRC to 0xFFFF, max_payload_len to 4096, both stream stages empty.
// Configuration: max_payload_len at APB byte address 0 (limit in use saturates
// at 4096); the user must write it only while the receiver is idle (not enforced).
module serial_frame_receiver_crc16 (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tuser,   // [0] opcode
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [7:0] data_byte, [23:8] frame_length,
                                  // [31:24] frame_address, [39:32] frame_protocol
  output logic        out_tlast,  // is_end
  output logic [2:0]  out_tuser,  // [2:0] status
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import sfr_pkg::*;

  // configuration register
  logic [12:0] max_len_r;
  logic        cfg_wr;
  logic [12:0] limit;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                      && (cfg_paddr[2] == REG_MAX_LEN);
  assign cfg_prdata = (cfg_paddr[2] == REG_MAX_LEN) ? {19'd0, max_len_r} : 32'd0;
  assign limit      = (max_len_r > MAX_PAYLOAD) ? MAX_PAYLOAD : max_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RESET;
    end else if (cfg_wr) begin
      max_len_r <= cfg_pwdata[12:0];
    end
  end

  // input register
  logic       in_vld_r, in_vld_nxt;
  logic       in_op_r;
  logic [7:0] in_byte_r;
  logic       push_ok;
  logic       fire;

  // Process the held beat when the result side has room; take a new beat
  // in the same cycle.
  assign fire      = in_vld_r && push_ok;
  assign in_tready = !in_vld_r || fire;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_tvalid && in_tready) begin
      in_vld_nxt = 1'b1;
    end else if (fire) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_op_r   <= in_tuser;
      in_byte_r <= in_tdata;
    end
  end

  // parser state
  phase_t      ph_r, ph_nxt;
  logic [1:0]  hidx_r, hidx_nxt;
  logic [15:0] len_r, len_nxt;
  logic [12:0] left_r, left_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  addr_r, addr_nxt;
  logic [7:0]  proto_r, proto_nxt;
  logic [7:0]  crch_r, crch_nxt;
  logic [15:0] crc_upd;
  logic        res_vld;
  result_t     res;

  assign crc_upd = crc16_byte(crc_r, in_byte_r);

  always_comb begin
    ph_nxt    = ph_r;
    hidx_nxt  = hidx_r;
    len_nxt   = len_r;
    left_nxt  = left_r;
    crc_nxt   = crc_r;
    addr_nxt  = addr_r;
    proto_nxt = proto_r;
    crch_nxt  = crch_r;
    res_vld   = 1'b0;
    res       = '0;
    if (fire) begin
      if (in_op_r == OP_TIMEOUT) begin
        // Timeout: mute before the header is complete, stopped after it.
        res_vld    = 1'b1;
        res.is_end = 1'b1;
        ph_nxt     = PH_IDLE;
        if (ph_r == PH_PAYLOAD || ph_r == PH_CRC_HI || ph_r == PH_CRC_LO) begin
          res.status         = ST_STOPPED;
          res.frame_length   = len_r;
          res.frame_address  = addr_r;
          res.frame_protocol = proto_r;
        end else begin
          res.status = ST_MUTE;
        end
      end else begin
        unique case (ph_r)
          PH_HEADER: begin
            crc_nxt = crc_upd;
            unique case (hidx_r)
              2'd0: len_nxt   = {in_byte_r, 8'h00};
              2'd1: len_nxt   = {len_r[15:8], in_byte_r};
              2'd2: addr_nxt  = in_byte_r;
              2'd3: proto_nxt = in_byte_r;
              default: len_nxt = len_r;
            endcase
            if (hidx_r != 2'd3) begin
              hidx_nxt = hidx_r + 2'd1;
            end else begin
              hidx_nxt = 2'd0;
              if (len_r > {3'd0, limit}) begin
                res_vld            = 1'b1;
                res.is_end         = 1'b1;
                res.status         = ST_TOO_LONG;
                res.frame_length   = len_r;
                res.frame_address  = addr_r;
                res.frame_protocol = in_byte_r;
                ph_nxt             = PH_IDLE;
              end else begin
                left_nxt = len_r[12:0];
                ph_nxt   = (len_r == 16'd0) ? PH_CRC_HI : PH_PAYLOAD;
              end
            end
          end
          PH_PAYLOAD: begin
            crc_nxt       = crc_upd;
            left_nxt      = left_r - 13'd1;
            if (left_r == 13'd1) begin
              ph_nxt = PH_CRC_HI;
            end
            res_vld       = 1'b1;
            res.data_byte = in_byte_r;
          end
          PH_CRC_HI: begin
            crch_nxt = in_byte_r;
            ph_nxt   = PH_CRC_LO;
          end
          PH_CRC_LO: begin
            res_vld            = 1'b1;
            res.is_end         = 1'b1;
            res.status         = ({crch_r, in_byte_r} == crc_r) ? ST_OK : ST_BAD_CRC;
            res.frame_length   = len_r;
            res.frame_address  = addr_r;
            res.frame_protocol = proto_r;
            ph_nxt             = PH_IDLE;
          end
          default: begin
            // Idle, and any unused phase code: check the start byte at once.
            if (in_byte_r != START_BYTE) begin
              res_vld    = 1'b1;
              res.is_end = 1'b1;
              res.status = ST_BAD_START;
              ph_nxt     = PH_IDLE;
            end else begin
              ph_nxt    = PH_HEADER;
              hidx_nxt  = 2'd0;
              crc_nxt   = CRC_INIT;
              len_nxt   = 16'd0;
              addr_nxt  = 8'd0;
              proto_nxt = 8'd0;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r    <= PH_IDLE;
      hidx_r  <= 2'd0;
      len_r   <= 16'd0;
      left_r  <= 13'd0;
      crc_r   <= CRC_INIT;
      addr_r  <= 8'd0;
      proto_r <= 8'd0;
      crch_r  <= 8'd0;
    end else begin
      ph_r    <= ph_nxt;
      hidx_r  <= hidx_nxt;
      len_r   <= len_nxt;
      left_r  <= left_nxt;
      crc_r   <= crc_nxt;
      addr_r  <= addr_nxt;
      proto_r <= proto_nxt;
      crch_r  <= crch_nxt;
    end
  end

  // result register and skid stage
  result_t out_res;

  sfr_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_vld  (res_vld),
    .push_data (res),
    .push_ok   (push_ok),
    .out_vld   (out_tvalid),
    .out_data  (out_res),
    .out_rdy   (out_tready)
  );

  assign out_tdata = {out_res.frame_protocol, out_res.frame_address,
                      out_res.frame_length, out_res.data_byte};
  assign out_tlast = out_res.is_end;
  assign out_tuser = out_res.status;

  // checks
  a_payload_status: assert property (@(posedge clk) disable iff (!rst_n)
    (res_vld && !res.is_end) |-> (res.status == ST_OK && ph_r == PH_PAYLOAD))
    else $error("payload beat with nonzero status or outside payload phase");

  a_end_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (res_vld && res.is_end) |=> (ph_r == PH_IDLE))
    else $error("parser not idle after an end result");

  a_payload_left: assert property (@(posedge clk) disable iff (!rst_n)
    (ph_r == PH_PAYLOAD) |-> (left_r != 13'd0))
    else $error("payload phase with no bytes left");

  a_start_init: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && ph_r == PH_IDLE && in_op_r == OP_BYTE && in_byte_r == START_BYTE)
    |=> (ph_r == PH_HEADER && crc_r == CRC_INIT && hidx_r == 2'd0))
    else $error("start byte did not open the header");

  a_no_result_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !push_ok) |=> in_vld_r)
    else $error("held input beat dropped while result side was full");

endmodule

// ----- verif/serial_frame_receiver_crc16_tb.sv -----
// Self-checking testbench for the CRC-16 framed serial receiver.
`timescale 1ns / 1ps

module serial_frame_receiver_crc16_tb;
  import sfr_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;     // time for the input and result registers to flush
  localparam int PHASE_ITEMS  = 110;   // five random phases give about 550 items
  localparam int HOLD_CYCLES  = 400;   // long receiver hold-off to back up the input

  typedef struct packed {
    logic       op;
    logic [7:0] rx_byte;
  } rx_item_t;

  typedef enum int {
    FL_NONE,
    FL_BAD_CRC,
    FL_CUT
  } frame_flaw_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;     // [7:0] rx_byte
  logic        in_tuser = 1'b0;   // [0] opcode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;         // [7:0] data_byte, [23:8] frame_length,
                                  // [31:24] frame_address, [39:32] frame_protocol
  logic        out_tlast;         // is_end
  logic [2:0]  out_tuser;         // [2:0] status
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Stimulus waiting to be driven, and result beats the parser model owes.
  rx_item_t rx_items[$];
  result_t  beats_due[$];
  rx_item_t next_item;
  result_t  want;

  int errors = 0;
  int cycle_count = 0;
  int sender_idle_pct = 0;
  int receiver_idle_pct = 0;
  int hold_left = 0;
  bit pressure_armed = 1'b0;
  bit pressure_done = 1'b0;

  // Parser model state, as it stands after reset.
  logic [12:0] max_len_reg = MAX_LEN_RESET;
  phase_t      rx_phase = PH_IDLE;
  logic [2:0]  hdr_idx = '0;
  logic [15:0] frame_len = '0;
  logic [15:0] bytes_left = '0;
  logic [15:0] crc_acc = CRC_INIT;
  logic [7:0]  hdr_addr = '0;
  logic [7:0]  hdr_proto = '0;
  logic [7:0]  crc_hi = '0;

  serial_frame_receiver_crc16 i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // CRC-16/CCITT-FALSE, one data bit at a time: feedback is the CRC MSB
  // xored with the incoming data bit.
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb  = crc[15] ^ b[i];
      crc = {crc[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return crc;
  endfunction

  function automatic logic [15:0] active_limit();
    return (max_len_reg > MAX_PAYLOAD) ? 16'(MAX_PAYLOAD) : 16'(max_len_reg);
  endfunction

  // Advance the parser model by one accepted input beat and queue the
  // result beat it owes, if any.
  task automatic parse_rx_item(input logic op, input logic [7:0] b);
    result_t r;
    r        = '0;
    r.is_end = 1'b1;
    if (op == OP_TIMEOUT) begin
      // Mute while the header is incomplete (idle included), stopped after it.
      if (rx_phase == PH_IDLE || rx_phase == PH_HEADER) begin
        r.status = ST_MUTE;
      end else begin
        r.status         = ST_STOPPED;
        r.frame_length   = frame_len;
        r.frame_address  = hdr_addr;
        r.frame_protocol = hdr_proto;
      end
      rx_phase = PH_IDLE;
      beats_due.push_back(r);
      return;
    end
    case (rx_phase)
      PH_HEADER: begin
        crc_acc = crc_step(crc_acc, b);
        case (hdr_idx)
          3'd0: frame_len = {b, 8'h00};
          3'd1: frame_len[7:0] = b;
          3'd2: hdr_addr = b;
          default: hdr_proto = b;
        endcase
        if (hdr_idx < 3'd3) begin
          hdr_idx++;
        end else begin
          hdr_idx = '0;
          if (frame_len > active_limit()) begin
            r.status         = ST_TOO_LONG;
            r.frame_length   = frame_len;
            r.frame_address  = hdr_addr;
            r.frame_protocol = hdr_proto;
            rx_phase         = PH_IDLE;
            beats_due.push_back(r);
          end else begin
            // A zero-length frame goes straight to the CRC bytes.
            bytes_left = frame_len;
            rx_phase   = (bytes_left == 0) ? PH_CRC_HI : PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        crc_acc    = crc_step(crc_acc, b);
        bytes_left = bytes_left - 16'd1;
        if (bytes_left == 0) begin
          rx_phase = PH_CRC_HI;
        end
        r.is_end    = 1'b0;
        r.data_byte = b;
        beats_due.push_back(r);
      end
      PH_CRC_HI: begin
        crc_hi   = b;
        rx_phase = PH_CRC_LO;
      end
      PH_CRC_LO: begin
        r.status         = ({crc_hi, b} == crc_acc) ? ST_OK : ST_BAD_CRC;
        r.frame_length   = frame_len;
        r.frame_address  = hdr_addr;
        r.frame_protocol = hdr_proto;
        rx_phase         = PH_IDLE;
        beats_due.push_back(r);
      end
      default: begin
        // Idle: anything but the start byte is rejected on the spot.
        if (b != START_BYTE) begin
          r.status = ST_BAD_START;
          beats_due.push_back(r);
        end else begin
          rx_phase  = PH_HEADER;
          hdr_idx   = '0;
          crc_acc   = CRC_INIT;
          frame_len = '0;
          hdr_addr  = '0;
          hdr_proto = '0;
        end
      end
    endcase
  endtask

  task automatic push_byte(input logic [7:0] b);
    rx_items.push_back('{op: OP_BYTE, rx_byte: b});
  endtask

  task automatic push_timeout();
    rx_items.push_back('{op: OP_TIMEOUT, rx_byte: 8'($urandom)});
  endtask

  // Queue one frame with random header bytes and payload. An over-long
  // frame stops after its header, since the receiver drops back to idle there.
  task automatic queue_frame(input logic [15:0] len, input frame_flaw_t flaw);
    logic [7:0]  bytes[$];
    logic [15:0] crc;
    int          cut_at;
    bytes = {START_BYTE, len[15:8], len[7:0], 8'($urandom), 8'($urandom)};
    if (len <= active_limit()) begin
      for (int i = 0; i < int'(len); i++) begin
        bytes.push_back(8'($urandom));
      end
      crc = CRC_INIT;
      for (int i = 1; i < bytes.size(); i++) begin
        crc = crc_step(crc, bytes[i]);
      end
      if (flaw == FL_BAD_CRC) begin
        crc ^= 16'($urandom_range(65535, 1));
      end
      bytes.push_back(crc[15:8]);
      bytes.push_back(crc[7:0]);
    end
    cut_at = (flaw == FL_CUT) ? $urandom_range(bytes.size() - 1, 1) : bytes.size();
    for (int i = 0; i < cut_at; i++) begin
      push_byte(bytes[i]);
    end
    if (flaw == FL_CUT) begin
      push_timeout();
    end
  endtask

  // Mostly well-formed frames with random content; the rest is over-long frames,
  // line noise, stray timeouts, corrupted CRCs and frames cut short.
  task automatic queue_random_traffic();
    int          start_size;
    int          pick;
    int          lim;
    logic [15:0] len;
    frame_flaw_t flaw;
    start_size = rx_items.size();
    lim        = int'(active_limit());
    while (rx_items.size() - start_size < PHASE_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        pick = $urandom_range(99);
        if (pick < 65) begin
          len = 16'($urandom_range((lim < 12) ? lim : 12, 0));
        end else if (pick < 78) begin
          len = (lim < 40) ? 16'(lim) : 16'($urandom_range(40, 13));
        end else if (pick < 90) begin
          len = 16'($urandom_range(65535, lim + 1));
        end else begin
          len = $urandom_range(1) ? 16'hFFFF : 16'(lim + 1);
        end
        pick = $urandom_range(99);
        flaw = (pick < 70) ? FL_NONE : (pick < 85) ? FL_BAD_CRC : FL_CUT;
        queue_frame(len, flaw);
      end else if (pick < 90) begin
        push_byte(8'($urandom));
      end else begin
        push_timeout();
      end
    end
    // Close the phase with a timeout so the parser is back at idle.
    push_timeout();
  endtask

  // Write max_payload_len, then read it back.
  task automatic write_max_len(input logic [12:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= 3'(4 * REG_MAX_LEN);
    cfg_pwdata  <= {19'd0, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    max_len_reg = value;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== {19'd0, value}) begin
      $error("max_payload_len readback: expected %0h, got %0h", value, cfg_prdata);
      errors++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Wait until every queued item is taken and every owed beat has come out,
  // then give the pipeline time to flush anything unexpected.
  task automatic settle();
    while (rx_items.size() != 0 || in_tvalid || beats_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Driver: hold a beat until it is taken, then offer the next one unless
  // the sender idles this cycle. Every taken beat advances the model.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        parse_rx_item(in_tuser, in_tdata);
      end
      if (!in_tvalid || in_tready) begin
        if (rx_items.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          next_item = rx_items.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= next_item.op;
          in_tdata  <= next_item.rx_byte;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result beat against the oldest owed beat, then pick
  // the next out_tready. Once armed, hold off for a long stretch so the
  // result stages fill and the input stalls.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (beats_due.size() == 0) begin
          $error("result beat with nothing owed: tdata %0h tlast %0b tuser %0d",
                 out_tdata, out_tlast, out_tuser);
          errors++;
        end else begin
          want = beats_due.pop_front();
          if (out_tdata[7:0] !== want.data_byte) begin
            $error("data_byte: expected %0h, got %0h", want.data_byte, out_tdata[7:0]);
            errors++;
          end
          if (out_tlast !== want.is_end) begin
            $error("is_end: expected %0b, got %0b", want.is_end, out_tlast);
            errors++;
          end
          if (out_tuser !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_tuser);
            errors++;
          end
          if (out_tdata[23:8] !== want.frame_length) begin
            $error("frame_length: expected %0h, got %0h", want.frame_length,
                   out_tdata[23:8]);
            errors++;
          end
          if (out_tdata[31:24] !== want.frame_address) begin
            $error("frame_address: expected %0h, got %0h", want.frame_address,
                   out_tdata[31:24]);
            errors++;
          end
          if (out_tdata[39:32] !== want.frame_protocol) begin
            $error("frame_protocol: expected %0h, got %0h", want.frame_protocol,
                   out_tdata[39:32]);
            errors++;
          end
        end
      end
      if (pressure_armed && !pressure_done && out_tvalid) begin
        pressure_done = 1'b1;
        hold_left     = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= receiver_idle_pct);
      end
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: sender idles 32%, receiver 77%.
    sender_idle_pct   = 32;
    receiver_idle_pct = 77;
    write_max_len(13'd20);
    push_byte(8'h00);                 // wrong start byte
    push_byte(8'hFF);                 // wrong start byte, all ones
    push_timeout();                   // timeout while idle: mute
    queue_frame(16'd0, FL_NONE);      // zero-length frame, CRC right after header
    push_byte(START_BYTE);            // timeout inside the header: mute
    push_byte(8'h00);
    push_timeout();
    push_byte(START_BYTE);            // timeout after the payload, before the CRC: stopped
    push_byte(8'h00);
    push_byte(8'h01);
    push_byte(8'hFF);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_timeout();
    push_byte(START_BYTE);            // maximum length, over the limit: too long
    push_byte(8'hFF);
    push_byte(8'hFF);
    push_byte(8'h00);
    push_byte(8'h00);
    settle();

    // Register above the build limit: saturates at 4096, so 4097 is too long.
    write_max_len(13'h1FFF);
    queue_frame(16'd4097, FL_NONE);
    queue_random_traffic();
    settle();

    // Zero limit: only empty frames get through.
    write_max_len(13'd0);
    queue_random_traffic();
    settle();

    // Swap the idling: sender 77%, receiver 32%.
    sender_idle_pct   = 77;
    receiver_idle_pct = 32;
    write_max_len(13'($urandom_range(40, 1)));
    queue_random_traffic();
    settle();

    // No idling; the receiver holds off once to back up the input.
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    write_max_len(MAX_PAYLOAD);
    pressure_armed = 1'b1;
    queue_random_traffic();
    settle();

    write_max_len(13'($urandom_range(16, 8)));
    queue_random_traffic();
    settle();

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
